@@ src/bmo3_pkg.sv @@
`default_nettype none

package bmo3_pkg;

    // Default size limits for the image.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field widths fixed by the interface.
    localparam int CFG_W   = 11;
    localparam int INDEX_W = 2;
    localparam int PIX_W   = 8;

    // Register indexes on the configuration channel.
    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_ELEMENT_SHAPE = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

    // Structuring elements, bit (row * 3 + col), row 0 on top.
    localparam logic [8:0] CROSS_MASK  = 9'b010_111_010;
    localparam logic [8:0] SQUARE_MASK = 9'b111_111_111;

    // Output pixel codes.
    localparam logic [PIX_W-1:0] PIX_FG = 8'd0;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd255;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    // One sample of the raster stream as the back end sees it.
    typedef struct packed {
        logic bg;     // background bit of the sample, outside samples are background
        logic first;  // first sample of a frame
        logic e_act;  // an eroded center exists for this sample
        logic emit;   // an opened result leaves for this sample
        logic last;   // that result is the last one of the frame
    } sample_t;

endpackage

`default_nettype wire

@@ src/bmo3_queue.sv @@
`default_nettype none

module bmo3_queue
    import bmo3_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire sample_t push_smp,
    output logic         full,
    input  wire logic    pop,
    output logic         empty,
    output sample_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sample_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_smp;
        end
    end

endmodule

`default_nettype wire

@@ src/bmo3_front.sv @@
`default_nettype none

module bmo3_front
    import bmo3_pkg::*;
#(
    parameter  int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter  int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1),
    localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int SEQ_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3)
)(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [PIX_W-1:0]   s_tdata,
    input  wire logic               s_tuser,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               q_full,
    output logic                    push,
    output sample_t                 push_smp,
    output logic                    clr,
    output logic [WW-1:0]           width,
    output logic [HW-1:0]           height,
    output logic                    shape
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             shape_reg;
    logic [1:0]       pend_reg;
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] in_cnt_reg;
    logic [TOT_W-1:0] in_cnt_next;
    logic [TOT_W-1:0] out_cnt_reg;
    logic [TOT_W-1:0] out_cnt_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic             fill_reg;
    logic             fill_next;

    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [SEQ_W-1:0] lag;
    logic [SEQ_W-1:0] e_thr;
    logic             cfg_wr;
    logic             accept;
    logic             is_pixel;
    logic             pixel_ok;
    logic             drain_ok;
    logic             push_pixel;

    // Sizes outside the supported range are clamped.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    assign width  = w_eff;
    assign height = h_eff;
    assign shape  = shape_reg;

    // A result trails its sample by two rows and two pixels.
    assign lag   = SEQ_W'({w_eff, 1'b0}) + SEQ_W'(2);
    assign e_thr = SEQ_W'(w_eff) + SEQ_W'(1);

    // Pixel count of a frame, registered after each size change.
    always_ff @(posedge aclk) begin
        total_reg <= TOT_W'({{HW{1'b0}}, w_eff} * {{WW{1'b0}}, h_eff});
    end

    // Configuration writes are taken at once; unknown indexes change nothing.
    assign cfg_ready = 1'b1;
    always_comb begin
        case (cfg_index)
            REG_IMAGE_WIDTH:   cfg_wr = cfg_valid;
            REG_IMAGE_HEIGHT:  cfg_wr = cfg_valid;
            REG_ELEMENT_SHAPE: cfg_wr = cfg_valid;
            default:           cfg_wr = 1'b0;
        endcase
    end
    assign clr = cfg_wr;

    // Classification of the incoming transaction.
    assign s_tready   = !q_full && !fill_reg && (pend_reg == '0);
    assign accept     = s_tvalid && s_tready;
    assign is_pixel   = (cmd_t'(s_tuser) == CMD_PIXEL);
    assign pixel_ok   = (in_cnt_reg < total_reg);
    assign drain_ok   = !pixel_ok && (out_cnt_reg < total_reg);
    assign push_pixel = accept && is_pixel && pixel_ok;

    // A drain that comes before the stream has reached the result lag
    // is followed by background samples until the result is due.
    always_comb begin
        push = (fill_reg && !q_full) || push_pixel || (accept && !is_pixel && drain_ok);

        push_smp.bg    = push_pixel ? (s_tdata != '0) : 1'b1;
        push_smp.first = (seq_reg == '0);
        push_smp.e_act = (seq_reg >= e_thr);
        push_smp.emit  = (seq_reg >= lag);
        push_smp.last  = push_smp.emit && (out_cnt_reg == total_reg - TOT_W'(1));

        seq_next     = seq_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        fill_next    = fill_reg;
        if (push) begin
            seq_next = seq_reg + SEQ_W'(1);
            if (push_pixel) begin
                in_cnt_next = in_cnt_reg + TOT_W'(1);
            end else begin
                fill_next = !push_smp.emit;
            end
            if (push_smp.emit) begin
                out_cnt_next = out_cnt_reg + TOT_W'(1);
            end
            if (push_smp.last) begin
                seq_next     = '0;
                in_cnt_next  = '0;
                out_cnt_next = '0;
            end
        end
    end

    // Registers and frame counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RESET_WIDTH;
            height_reg  <= RESET_HEIGHT;
            shape_reg   <= 1'b0;
            pend_reg    <= 2'b11;
            seq_reg     <= '0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            fill_reg    <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_ELEMENT_SHAPE: shape_reg  <= cfg_data[0];
                default:           shape_reg  <= shape_reg;
            endcase
            // Hold off input until the frame size has settled.
            pend_reg    <= 2'b11;
            seq_reg     <= '0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            fill_reg    <= 1'b0;
        end else begin
            pend_reg    <= {pend_reg[0], 1'b0};
            seq_reg     <= seq_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            fill_reg    <= fill_next;
        end
    end

endmodule

`default_nettype wire

@@ src/bmo3_window.sv @@
`default_nettype none

module bmo3_window
    import bmo3_pkg::*;
#(
    parameter  int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter  int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1),
    localparam int ROW_W = $clog2(MAX_HEIGHT + 3)
)(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          clr,
    input  wire logic          dilate,
    input  wire logic          shape,
    input  wire logic [WW-1:0] width,
    input  wire logic [HW-1:0] height,
    input  wire logic          in_valid,
    input  wire logic          in_bit,
    input  wire sample_t       in_smp,
    output logic               out_valid,
    output logic               out_bit,
    output sample_t            out_smp
);

    // Two line delays of one row each.
    logic line_a_mem [MAX_WIDTH];
    logic line_b_mem [MAX_WIDTH];

    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] ptr_a_reg;
    logic [COL_W-1:0] ptr_b_reg;

    logic             v1_reg;
    logic             bit1_reg;
    logic             rd_a_reg;
    sample_t          smp1_reg;

    logic             v2_reg;
    logic             x0_reg;
    logic             x1_reg;
    logic             rd_b_reg;
    sample_t          smp2_reg;

    logic             v3_reg;
    sample_t          smp3_reg;
    logic [2:0]       win_top_reg;
    logic [2:0]       win_mid_reg;
    logic [2:0]       win_bot_reg;
    logic [ROW_W-1:0] row3_reg;
    logic [COL_W-1:0] col3_reg;

    logic [ROW_W-1:0] cnt_row_reg;
    logic [COL_W-1:0] cnt_col_reg;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic             act2;

    logic             v4_reg;
    logic             bit4_reg;
    sample_t          smp4_reg;

    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [2:0]       win [3];
    logic [8:0]       mask;
    logic             erode_bg;
    logic             dilate_bg;

    assign last_col = COL_W'(width - WW'(1));

    // Stage 1: first line delay, read before write at the same column.
    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            rd_a_reg              <= line_a_mem[ptr_a_reg];
            line_a_mem[ptr_a_reg] <= in_bit;
        end
        if (adv) begin
            bit1_reg <= in_bit;
            smp1_reg <= in_smp;
        end
    end

    // Stage 2: second line delay fed by the first.
    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            rd_b_reg              <= line_b_mem[ptr_b_reg];
            line_b_mem[ptr_b_reg] <= rd_a_reg;
        end
        if (adv) begin
            x0_reg   <= bit1_reg;
            x1_reg   <= rd_a_reg;
            smp2_reg <= smp1_reg;
        end
    end

    // Center position of the window: restarts with each frame.
    assign act2    = dilate ? smp2_reg.emit : smp2_reg.e_act;
    assign cur_row = smp2_reg.first ? '0 : cnt_row_reg;
    assign cur_col = smp2_reg.first ? '0 : cnt_col_reg;

    // Stage 3: shift the 3x3 window and latch the center position.
    always_ff @(posedge aclk) begin
        if (adv && v2_reg) begin
            win_top_reg <= {win_top_reg[1:0], rd_b_reg};
            win_mid_reg <= {win_mid_reg[1:0], x1_reg};
            win_bot_reg <= {win_bot_reg[1:0], x0_reg};
        end
        if (adv) begin
            smp3_reg <= smp2_reg;
            row3_reg <= cur_row;
            col3_reg <= cur_col;
        end
    end

    // Neighbors that fall outside the image are treated as background.
    assign row_ok[0] = (row3_reg != '0);
    assign row_ok[1] = 1'b1;
    assign row_ok[2] = ((ROW_W + 1)'(row3_reg) + (ROW_W + 1)'(1)) < (ROW_W + 1)'(height);
    assign col_ok[0] = (col3_reg != '0);
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = (col3_reg != last_col);

    assign win[0] = win_top_reg;
    assign win[1] = win_mid_reg;
    assign win[2] = win_bot_reg;
    assign mask   = shape ? SQUARE_MASK : CROSS_MASK;

    // Erosion is background if any element tap is; dilation only if all are.
    always_comb begin
        erode_bg  = 1'b0;
        dilate_bg = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (mask[i * 3 + j]) begin
                    erode_bg  = erode_bg | !(row_ok[i] && col_ok[j]) | win[i][2 - j];
                    dilate_bg = dilate_bg & (!(row_ok[i] && col_ok[j]) | win[i][2 - j]);
                end
            end
        end
    end

    // Stage 4: registered window result.
    always_ff @(posedge aclk) begin
        if (adv) begin
            bit4_reg <= dilate ? dilate_bg : erode_bg;
            smp4_reg <= smp3_reg;
        end
    end

    // Valid bits, line pointers and the position counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            ptr_a_reg   <= '0;
            ptr_b_reg   <= '0;
            cnt_row_reg <= '0;
            cnt_col_reg <= '0;
        end else if (clr) begin
            ptr_a_reg   <= '0;
            ptr_b_reg   <= '0;
            cnt_row_reg <= '0;
            cnt_col_reg <= '0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (in_valid) begin
                ptr_a_reg <= (ptr_a_reg == last_col) ? '0 : ptr_a_reg + COL_W'(1);
            end
            if (v1_reg) begin
                ptr_b_reg <= (ptr_b_reg == last_col) ? '0 : ptr_b_reg + COL_W'(1);
            end
            if (v2_reg && (smp2_reg.first || act2)) begin
                if (!act2) begin
                    cnt_row_reg <= cur_row;
                    cnt_col_reg <= cur_col;
                end else if (cur_col == last_col) begin
                    cnt_row_reg <= cur_row + ROW_W'(1);
                    cnt_col_reg <= '0;
                end else begin
                    cnt_row_reg <= cur_row;
                    cnt_col_reg <= cur_col + COL_W'(1);
                end
            end
        end
    end

    assign out_valid = v4_reg;
    assign out_bit   = bit4_reg;
    assign out_smp   = smp4_reg;

endmodule

`default_nettype wire

@@ src/binary_morph_opening_3x3_core.sv @@
`default_nettype none

// A result passes from the taken transaction that causes it through the queue,
// four stages of erosion, four of dilation and one output stage before it is presented.
// Throughput: one pixel or drain transaction per cycle while s_tready is high; a drain
// that arrives before two rows and two pixels have streamed in is stretched by background
// fill samples, one per cycle while the queue is not full, set by the line delay depth.
// Reset: synchronous, active low; registers return to 640 x 480 with the cross element,
// and input is held off after reset and after each register write until pend_reg clears.

module binary_morph_opening_3x3_core
    import bmo3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [PIX_W-1:0]   s_tdata,    // [7:0] pixel_value
    input  wire logic               s_tuser,    // [0] cmd
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [PIX_W-1:0]        m_tdata,    // [7:0] result_pixel
    output logic                    m_tlast,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic          q_full;
    logic          q_empty;
    logic          push;
    sample_t       push_smp;
    sample_t       q_head;
    logic          clr;
    logic [WW-1:0] width;
    logic [HW-1:0] height;
    logic          shape;
    logic          adv;

    logic          ero_valid;
    logic          ero_bit;
    sample_t       ero_smp;
    logic          dil_valid;
    logic          dil_bit;
    sample_t       dil_smp;

    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    // The back end moves whenever the output register can take a result.
    assign adv = !m_tvalid_reg || m_tready;

    bmo3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_smp  (push_smp),
        .clr       (clr),
        .width     (width),
        .height    (height),
        .shape     (shape)
    );

    bmo3_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_smp (push_smp),
        .full     (q_full),
        .pop      (adv && !q_empty),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Erosion of the input stream.
    bmo3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_erode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .clr       (clr),
        .dilate    (1'b0),
        .shape     (shape),
        .width     (width),
        .height    (height),
        .in_valid  (!q_empty),
        .in_bit    (q_head.bg),
        .in_smp    (q_head),
        .out_valid (ero_valid),
        .out_bit   (ero_bit),
        .out_smp   (ero_smp)
    );

    // Dilation of the eroded stream.
    bmo3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dilate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .clr       (clr),
        .dilate    (1'b1),
        .shape     (shape),
        .width     (width),
        .height    (height),
        .in_valid  (ero_valid),
        .in_bit    (ero_bit),
        .in_smp    (ero_smp),
        .out_valid (dil_valid),
        .out_bit   (dil_bit),
        .out_smp   (dil_smp)
    );

    // Output register: loads a result for each sample that carries one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dil_valid && dil_smp.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= dil_bit ? PIX_BG : PIX_FG;
            m_tlast_reg <= dil_smp.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A result leaving the window chain always reaches the output.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && dil_valid && dil_smp.emit) |=> m_tvalid)
        else $error("result sample lost before the output register");

    // Results are binary.
    a_binary_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == PIX_FG || m_tdata == PIX_BG))
        else $error("result pixel is neither foreground nor background");

    // Input is held off while a new frame width settles.
    a_cfg_holdoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == REG_IMAGE_WIDTH) |=> !s_tready)
        else $error("input accepted right after a size change");

endmodule

`default_nettype wire

@@ dv/tb_binary_morph_opening_3x3_core.sv @@
`timescale 1ns / 100ps

module tb_binary_morph_opening_3x3_core;
    import bmo3_pkg::*;

    localparam int FRAME_CAP = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } opened_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [PIX_W-1:0]   m_tdata;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    binary_morph_opening_3x3_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: registers, frame counters and the pixels of the current frame.
    logic [CFG_W-1:0] pred_width;
    logic [CFG_W-1:0] pred_height;
    logic             pred_square;
    int               pixels_in;
    int               results_out;
    bit               frame_bg [0:FRAME_CAP-1];
    opened_t          opened_q[$];

    int error_count;
    bit idle_en;
    int hold_cycles;
    int pixels_sent;

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int eff_width();
        if (pred_width < 1) return 1;
        if (pred_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(pred_width);
    endfunction

    function automatic int eff_height();
        if (pred_height < 1) return 1;
        if (pred_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return int'(pred_height);
    endfunction

    function automatic logic [8:0] element_mask();
        return pred_square ? SQUARE_MASK : CROSS_MASK;
    endfunction

    // Eroded image is background at (r, c) unless every element pixel is inside and zero.
    function automatic bit eroded_is_bg(int r, int c, int w, int h);
        logic [8:0] mask;
        int rr, cc;
        mask = element_mask();
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rr = r + i - 1;
                cc = c + j - 1;
                if (mask[i*3+j]) begin
                    if (rr < 0 || rr >= h || cc < 0 || cc >= w) return 1'b1;
                    if (frame_bg[rr*w+cc]) return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Dilation of the eroded image at raster index k; outside positions are skipped.
    function automatic logic [PIX_W-1:0] opened_value(int k, int w, int h);
        logic [8:0] mask;
        int r, c, rr, cc;
        mask = element_mask();
        r = k / w;
        c = k % w;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rr = r + i - 1;
                cc = c + j - 1;
                if (mask[i*3+j] && rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                    if (!eroded_is_bg(rr, cc, w, h)) return PIX_FG;
                end
            end
        end
        return PIX_BG;
    endfunction

    function automatic void emit_result(int w, int h);
        opened_t item;
        int total;
        total = w * h;
        item.pixel = opened_value(results_out, w, h);
        item.last = (results_out == total - 1);
        opened_q.push_back(item);
        results_out++;
        if (results_out >= total) begin
            results_out = 0;
            pixels_in = 0;
        end
    endfunction

    // Updates the prediction for one accepted input transaction.
    function automatic void predict_opening(cmd_t cmd, logic [PIX_W-1:0] pix);
        int w, h, total;
        w = eff_width();
        h = eff_height();
        total = w * h;
        if (cmd == CMD_PIXEL) begin
            if (pixels_in >= total) return;
            frame_bg[pixels_in] = (pix != 0);
            pixels_in++;
            if (pixels_in > results_out + 2 * w + 2) emit_result(w, h);
        end else begin
            if (pixels_in < total || results_out >= total) return;
            emit_result(w, h);
        end
    endfunction

    // Sends one input transaction and updates the prediction when it is taken.
    task automatic send_item(cmd_t cmd, logic [PIX_W-1:0] pix);
        int gap;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = pix;
        do @(posedge aclk); while (!s_tready);
        predict_opening(cmd, pix);
        if (cmd == CMD_PIXEL) pixels_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:   pred_width = value;
            REG_IMAGE_HEIGHT:  pred_height = value;
            REG_ELEMENT_SHAPE: pred_square = value[0];
            default: ;
        endcase
        pixels_in = 0;
        results_out = 0;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_results_done();
        while (opened_q.size() != 0) @(posedge aclk);
    endtask

    // Waits until the block is idle before a register write.
    task automatic settle();
        stop_sending();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, bit square);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_ELEMENT_SHAPE, {{(CFG_W-1){1'b0}}, square});
    endtask

    function automatic logic [PIX_W-1:0] random_pixel(int fg_pct);
        if ($urandom_range(0, 99) < fg_pct) return PIX_FG;
        return PIX_W'($urandom_range(1, 255));
    endfunction

    // Streams one whole frame and drains it; noise adds early drains and surplus pixels.
    task automatic send_frame(int fg_pct, bit noise, int pause_at);
        int total;
        total = eff_width() * eff_height();
        for (int i = 0; i < total; i++) begin
            if (noise && $urandom_range(0, 39) == 0) send_item(CMD_DRAIN, PIX_FG);
            if (i == pause_at) begin
                stop_sending();
                wait_results_done();
            end
            send_item(CMD_PIXEL, random_pixel(fg_pct));
        end
        while (pixels_in != 0) begin
            if (noise && $urandom_range(0, 19) == 0) send_item(CMD_PIXEL, random_pixel(50));
            send_item(CMD_DRAIN, PIX_FG);
        end
    endtask

    // A partial frame at the reset size, an early drain, then a restart by register write.
    task automatic test_reset_size_restart();
        for (int i = 0; i < 6; i++) send_item(CMD_PIXEL, random_pixel(50));
        send_item(CMD_DRAIN, PIX_FG);
        configure(11'd3, 11'd3, 1'b0);
        send_frame(100, 1'b0, -1);
    endtask

    // Size extremes, both elements, and the pixel value extremes.
    task automatic test_directed();
        logic [PIX_W-1:0] extremes [4] = '{8'd0, 8'd255, 8'd1, 8'd128};
        configure(11'd0, 11'd0, 1'b0);
        send_frame(100, 1'b0, -1);
        configure(11'd0, 11'd0, 1'b1);
        send_frame(0, 1'b0, -1);
        configure(11'd3, 11'd3, 1'b1);
        send_frame(100, 1'b0, -1);
        configure(11'd4, 11'd3, 1'b0);
        for (int i = 0; i < 12; i++) send_item(CMD_PIXEL, extremes[i % 4]);
        while (pixels_in != 0) send_item(CMD_DRAIN, PIX_FG);
        configure(11'd1, 11'd2047, 1'b0);
        send_frame(80, 1'b0, -1);
    endtask

    // Long receiver hold-off fills the block; then a sender pause mid-frame.
    task automatic test_backpressure();
        configure(11'd8, 11'd8, 1'b1);
        hold_cycles = 300;
        send_frame(70, 1'b0, -1);
        configure(11'd6, 11'd6, 1'b0);
        send_frame(70, 1'b0, 25);
    endtask

    task automatic test_random_frames(int target, bit noise);
        while (pixels_sent < target) begin
            if ($urandom_range(0, 3) != 0)
                configure(CFG_W'($urandom_range(1, 10)), CFG_W'($urandom_range(1, 8)),
                          1'($urandom_range(0, 1)));
            send_frame($urandom_range(40, 90), noise, -1);
        end
    endtask

    // Result checker.
    always @(posedge aclk) begin
        opened_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (opened_q.size() == 0) begin
                $error("result_pixel: unexpected result, actual %0d", m_tdata);
                error_count++;
            end else begin
                exp_item = opened_q.pop_front();
                if (m_tdata !== exp_item.pixel) begin
                    $error("result_pixel: expected %0d, actual %0d", exp_item.pixel, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_item.last) begin
                    $error("last_pixel: expected %0d, actual %0d", exp_item.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts plus a counted hold-off when requested.
    initial begin
        int burst;
        burst = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready = 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_tready = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 2);
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Test sequence.
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_PIXEL;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        aresetn = 1'b0;
        error_count = 0;
        idle_en = 1'b1;
        hold_cycles = 0;
        pixels_sent = 0;
        pred_width = RESET_WIDTH;
        pred_height = RESET_HEIGHT;
        pred_square = 1'b0;
        pixels_in = 0;
        results_out = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_size_restart();
        test_directed();
        test_backpressure();
        pixels_sent = 0;
        test_random_frames(100, 1'b1);
        idle_en = 1'b0;
        test_random_frames(200, 1'b0);

        settle();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ binary_morph_opening_3x3_core.f @@
src/bmo3_pkg.sv
src/bmo3_queue.sv
src/bmo3_front.sv
src/bmo3_window.sv
src/binary_morph_opening_3x3_core.sv
dv/tb_binary_morph_opening_3x3_core.sv
